### design/tpfd_pkg.sv
`timescale 1ns / 1ps

package tpfd_pkg;

    localparam logic [2:0] CFG_DURATION  = 3'd0;
    localparam logic [2:0] CFG_PERIOD    = 3'd1;
    localparam logic [2:0] CFG_ACCEL     = 3'd2;
    localparam logic [2:0] CFG_START_POS = 3'd3;
    localparam logic [2:0] CFG_END_POS   = 3'd4;

    localparam logic [30:0] SMAX31  = 31'h7FFF_FFFF;
    localparam logic [95:0] MAG_CAP = 96'h1 << 40;

    // Adds or subtracts a magnitude to a 32-bit base and saturates to 32 bits.
    function automatic logic [31:0] tpfd_addmag(input logic [31:0] base,
                                                input logic [95:0] mag,
                                                input logic neg);
        logic [42:0] m;
        logic [42:0] b;
        logic [42:0] s;
        logic [31:0] r;
        m = (mag > MAG_CAP) ? 43'(MAG_CAP) : mag[42:0];
        b = {{11{base[31]}}, base};
        s = neg ? (b - m) : (b + m);
        if (!s[42] && (s[41:31] != 11'd0)) begin
            r = 32'h7FFF_FFFF;
        end else if (s[42] && (s[41:31] != 11'h7FF)) begin
            r = 32'h8000_0000;
        end else begin
            r = s[31:0];
        end
        return r;
    endfunction

endpackage

### design/trapezoid_profile_fixed_duration_core.sv
`timescale 1ns / 1ps

// Trapezoidal velocity profile generator of fixed duration, signed fixed point.
// Configuration is written through i_cfg_we, i_cfg_addr and i_cfg_data by the user only
// while the block is idle; the block does not enforce it. Registers are read live on every request.
// The input channel carries one request per sample: i_restart high plans a new
// move and returns sample zero, low returns the next sample.
// The output channel returns one sample per request: time, position, velocity,
// acceleration, a last-sample flag and a finished flag.
// Arithmetic runs on a shift-add multiplier that retires one multiplier bit
// per cycle, a restoring divider that retires one quotient bit per cycle, and
// a square root unit that retires one root bit per cycle.
// A plain request is accepted, forms k*dt and up to three further products,
// then delivers its sample. A restart request first plans the move with two
// divisions, three products and, unless the move is triangular, a square root.
// Reset restores the register defaults and clears the plan, so a request
// before any restart returns a finished sample at the end position.
// A finished sample waits in the output register while the receiver stalls;
// the next request is taken meanwhile, and its result waits until that
// register is free.
module trapezoid_profile_fixed_duration_core
    import tpfd_pkg::*;
#(
    parameter int FRAC_BITS = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_addr,
    input  logic [31:0] i_cfg_data,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic        i_restart,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [31:0] o_sample_time,
    output logic [31:0] o_position,
    output logic [31:0] o_velocity,
    output logic [31:0] o_acceleration,
    output logic        o_last_sample,
    output logic        o_finished
);

    localparam int SH_POS = 2 * FRAC_BITS + 1;

    typedef enum logic [3:0] {
        ST_IDLE, ST_TT, ST_LHS, ST_DIV, ST_SQRT, ST_CM, ST_TOT,
        ST_KT, ST_SQ, ST_PA, ST_VA, ST_CR, ST_OUT
    } t_state;

    t_state r_state;

    logic [31:0] r_dur, r_period, r_start, r_end;
    logic [30:0] r_accel;

    logic [31:0] r_k, r_ta, r_total;
    logic [30:0] r_am, r_cm;
    logic        r_neg, r_tri, r_decel;

    logic [95:0] r_mx, r_acc;
    logic [31:0] r_my;
    logic [95:0] r_dn;
    logic [63:0] r_dm, r_rem;
    logic [6:0]  r_cnt;
    logic [63:0] r_sx;
    logic [32:0] r_srem;
    logic [31:0] r_root;
    logic [5:0]  r_scnt;

    logic [63:0] r_tt, r_t;

    logic [31:0] r_res_time, r_res_pos, r_res_vel, r_res_acc;
    logic        r_res_last, r_res_fin;

    logic        r_out_valid;
    logic [31:0] r_o_time, r_o_pos, r_o_vel, r_o_acc;
    logic        r_o_last, r_o_fin;

    logic [31:0] w_dt;
    logic [32:0] w_d, w_dabs;
    logic [95:0] w_rhs;
    logic [95:0] w_mul_next;
    logic [64:0] w_rem_sh, w_rem_sub;
    logic        w_div_ge;
    logic [34:0] w_srs, w_trial, w_ssub;
    logic        w_sq_ge;
    logic [31:0] w_ta_tri, w_rc, w_ta_sq;
    logic [30:0] w_tri_mag, w_cm;
    logic [63:0] w_sq_in;
    logic [95:0] w_cm_sh;
    logic [31:0] w_am32, w_cm32, w_sacc, w_scru;
    logic [63:0] w_t;
    logic [32:0] w_t_cru;
    logic        w_hold, w_in_ramp, w_in_cruise;
    logic [33:0] w_cru_x;
    logic [31:0] w_u, w_w;
    logic [95:0] w_t_by_dur;

    assign w_dt      = (r_period == 32'd0) ? 32'd1 : r_period;
    assign w_d       = {r_end[31], r_end} - {r_start[31], r_start};
    assign w_dabs    = w_d[32] ? (33'd0 - w_d) : w_d;
    assign w_rhs     = {61'd0, w_dabs, 2'b00} << (2 * FRAC_BITS);

    assign w_mul_next = r_acc + (r_my[0] ? r_mx : 96'd0);

    assign w_rem_sh  = {r_rem, r_dn[95]};
    assign w_div_ge  = (w_rem_sh >= {1'b0, r_dm});
    assign w_rem_sub = w_rem_sh - {1'b0, r_dm};

    assign w_srs     = {r_srem, r_sx[63:62]};
    assign w_trial   = {1'b0, r_root, 2'b01};
    assign w_sq_ge   = (w_srs >= w_trial);
    assign w_ssub    = w_srs - w_trial;

    assign w_ta_tri  = r_dur >> 1;
    assign w_rc      = (r_root > r_dur) ? r_dur : r_root;
    assign w_ta_sq   = (r_dur - w_rc) >> 1;
    assign w_tri_mag = ((r_dm == 64'd0) || (r_dn[95:31] != 65'd0)) ? SMAX31 : r_dn[30:0];
    assign w_sq_in   = ((r_dm == 64'd0) || (r_dn[95:64] != 32'd0)) ? 64'hFFFF_FFFF_FFFF_FFFF
                                                                   : r_dn[63:0];
    assign w_cm_sh   = r_acc >> FRAC_BITS;
    assign w_cm      = (w_cm_sh[95:31] != 65'd0) ? SMAX31 : w_cm_sh[30:0];

    assign w_am32    = {1'b0, r_am};
    assign w_cm32    = {1'b0, r_cm};
    assign w_sacc    = r_neg ? (32'd0 - w_am32) : w_am32;
    assign w_scru    = r_neg ? (32'd0 - w_cm32) : w_cm32;

    assign w_t         = r_acc[63:0];
    assign w_t_cru     = {1'b0, r_dur} - {1'b0, r_ta};
    assign w_hold      = (r_k > r_total) || (w_t > {32'd0, r_dur});
    assign w_in_ramp   = (w_t <= {32'd0, r_ta});
    assign w_in_cruise = !w_t_cru[32] && (w_t <= {32'd0, w_t_cru[31:0]});
    assign w_cru_x     = {1'b0, w_t[31:0], 1'b0} - {2'b00, r_ta};
    assign w_u         = r_dur - w_t[31:0];
    assign w_w         = r_t[31:0] + r_ta - r_dur;
    assign w_t_by_dur  = {63'd0, r_dur, 1'b0} + {64'd0, w_dt};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
            r_my        <= 32'd0;
            r_cnt       <= 7'd0;
            r_scnt      <= 6'd0;
            r_dur       <= 32'd65536;
            r_period    <= 32'd655;
            r_accel     <= 31'd65536;
            r_start     <= 32'd0;
            r_end       <= 32'd0;
            r_k         <= 32'd0;
            r_ta        <= 32'd0;
            r_total     <= 32'd0;
            r_am        <= 31'd0;
            r_cm        <= 31'd0;
            r_neg       <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_addr)
                    CFG_DURATION:  r_dur    <= i_cfg_data;
                    CFG_PERIOD:    r_period <= i_cfg_data;
                    CFG_ACCEL:     r_accel  <= i_cfg_data[30:0];
                    CFG_START_POS: r_start  <= i_cfg_data;
                    CFG_END_POS:   r_end    <= i_cfg_data;
                    default: ;
                endcase
            end

            if (r_my != 32'd0) begin
                r_acc <= w_mul_next;
                r_mx  <= r_mx << 1;
                r_my  <= r_my >> 1;
            end
            if (r_cnt != 7'd0) begin
                r_cnt <= r_cnt - 7'd1;
                r_dn  <= {r_dn[94:0], w_div_ge};
                r_rem <= w_div_ge ? w_rem_sub[63:0] : w_rem_sh[63:0];
            end
            if (r_scnt != 6'd0) begin
                r_scnt <= r_scnt - 6'd1;
                r_sx   <= r_sx << 2;
                r_srem <= w_sq_ge ? w_ssub[32:0] : w_srs[32:0];
                r_root <= {r_root[30:0], w_sq_ge};
            end

            if (r_out_valid && i_out_ready && (r_state != ST_OUT)) begin
                r_out_valid <= 1'b0;
            end

            case (r_state)
                ST_IDLE: begin
                    if (i_in_valid) begin
                        r_acc <= 96'd0;
                        if (i_restart) begin
                            r_mx    <= {64'd0, r_dur};
                            r_my    <= r_dur;
                            r_state <= ST_TT;
                        end else begin
                            if (r_k != 32'hFFFF_FFFF) begin
                                r_k  <= r_k + 32'd1;
                                r_mx <= {64'd0, r_k + 32'd1};
                            end else begin
                                r_mx <= {64'd0, r_k};
                            end
                            r_my    <= w_dt;
                            r_state <= ST_KT;
                        end
                    end
                end
                ST_TT: begin
                    if (r_my == 32'd0) begin
                        r_tt    <= r_acc[63:0];
                        r_mx    <= {32'd0, r_acc[63:0]};
                        r_my    <= {1'b0, r_accel};
                        r_acc   <= 96'd0;
                        r_state <= ST_LHS;
                    end
                end
                ST_LHS: begin
                    if (r_my == 32'd0) begin
                        r_rem <= 64'd0;
                        r_cnt <= 7'd96;
                        if (r_acc < w_rhs) begin
                            r_tri <= 1'b1;
                            r_dn  <= w_rhs;
                            r_dm  <= r_tt;
                        end else begin
                            r_tri <= 1'b0;
                            r_dn  <= r_acc - w_rhs;
                            r_dm  <= {33'd0, r_accel};
                        end
                        r_state <= ST_DIV;
                    end
                end
                ST_DIV: begin
                    if (r_cnt == 7'd0) begin
                        if (r_tri) begin
                            r_am    <= w_tri_mag;
                            r_ta    <= w_ta_tri;
                            r_mx    <= {64'd0, w_ta_tri};
                            r_my    <= {1'b0, w_tri_mag};
                            r_acc   <= 96'd0;
                            r_state <= ST_CM;
                        end else begin
                            r_am    <= r_accel;
                            r_sx    <= w_sq_in;
                            r_srem  <= 33'd0;
                            r_root  <= 32'd0;
                            r_scnt  <= 6'd32;
                            r_state <= ST_SQRT;
                        end
                    end
                end
                ST_SQRT: begin
                    if (r_scnt == 6'd0) begin
                        r_ta    <= w_ta_sq;
                        r_mx    <= {64'd0, w_ta_sq};
                        r_my    <= w_am32;
                        r_acc   <= 96'd0;
                        r_state <= ST_CM;
                    end
                end
                ST_CM: begin
                    if (r_my == 32'd0) begin
                        r_cm    <= w_cm;
                        r_neg   <= w_d[32];
                        r_dn    <= w_t_by_dur;
                        r_dm    <= {31'd0, w_dt, 1'b0};
                        r_rem   <= 64'd0;
                        r_cnt   <= 7'd96;
                        r_state <= ST_TOT;
                    end
                end
                ST_TOT: begin
                    if (r_cnt == 7'd0) begin
                        r_total <= r_dn[31:0];
                        r_k     <= 32'd0;
                        r_mx    <= 96'd0;
                        r_my    <= w_dt;
                        r_acc   <= 96'd0;
                        r_state <= ST_KT;
                    end
                end
                ST_KT: begin
                    if (r_my == 32'd0) begin
                        r_t        <= w_t;
                        r_res_time <= (w_t[63:32] != 32'd0) ? 32'hFFFF_FFFF : w_t[31:0];
                        r_res_last <= (r_k == r_total);
                        r_res_fin  <= (r_k > r_total);
                        r_acc      <= 96'd0;
                        if (w_hold) begin
                            r_res_pos <= r_end;
                            r_res_vel <= 32'd0;
                            r_res_acc <= 32'd0;
                            r_state   <= ST_OUT;
                        end else if (w_in_ramp) begin
                            r_decel   <= 1'b0;
                            r_res_acc <= w_sacc;
                            r_mx      <= {64'd0, w_t[31:0]};
                            r_my      <= w_t[31:0];
                            r_state   <= ST_SQ;
                        end else if (w_in_cruise) begin
                            r_res_acc <= 32'd0;
                            r_res_vel <= w_scru;
                            r_mx      <= {62'd0, w_cru_x};
                            r_my      <= w_cm32;
                            r_state   <= ST_CR;
                        end else begin
                            r_decel   <= 1'b1;
                            r_res_acc <= 32'd0 - w_sacc;
                            r_mx      <= {64'd0, w_u};
                            r_my      <= w_u;
                            r_state   <= ST_SQ;
                        end
                    end
                end
                ST_SQ: begin
                    if (r_my == 32'd0) begin
                        r_mx    <= {32'd0, r_acc[63:0]};
                        r_my    <= w_am32;
                        r_acc   <= 96'd0;
                        r_state <= ST_PA;
                    end
                end
                ST_PA: begin
                    if (r_my == 32'd0) begin
                        if (r_decel) begin
                            r_res_pos <= tpfd_addmag(r_end, r_acc >> SH_POS, !r_neg);
                            r_mx      <= {64'd0, w_w};
                        end else begin
                            r_res_pos <= tpfd_addmag(r_start, r_acc >> SH_POS, r_neg);
                            r_mx      <= {64'd0, r_t[31:0]};
                        end
                        r_my    <= w_am32;
                        r_acc   <= 96'd0;
                        r_state <= ST_VA;
                    end
                end
                ST_VA: begin
                    if (r_my == 32'd0) begin
                        if (r_decel) begin
                            r_res_vel <= tpfd_addmag(w_scru, r_acc >> FRAC_BITS, !r_neg);
                        end else begin
                            r_res_vel <= tpfd_addmag(32'd0, r_acc >> FRAC_BITS, r_neg);
                        end
                        r_state <= ST_OUT;
                    end
                end
                ST_CR: begin
                    if (r_my == 32'd0) begin
                        r_res_pos <= tpfd_addmag(r_start, r_acc >> (FRAC_BITS + 1), r_neg);
                        r_state   <= ST_OUT;
                    end
                end
                ST_OUT: begin
                    if (!r_out_valid || i_out_ready) begin
                        r_out_valid <= 1'b1;
                        r_o_time    <= r_res_time;
                        r_o_pos     <= r_res_pos;
                        r_o_vel     <= r_res_vel;
                        r_o_acc     <= r_res_acc;
                        r_o_last    <= r_res_last;
                        r_o_fin     <= r_res_fin;
                        r_state     <= ST_IDLE;
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    assign o_in_ready     = (r_state == ST_IDLE);
    assign o_out_valid    = r_out_valid;
    assign o_sample_time  = r_o_time;
    assign o_position     = r_o_pos;
    assign o_velocity     = r_o_vel;
    assign o_acceleration = r_o_acc;
    assign o_last_sample  = r_o_last;
    assign o_finished     = r_o_fin;

endmodule
